### design/gss_pkg.sv
// Shared types and constants for the gripper stall-sense sequencer.
package gss_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_ZERO_POINT = 3'd0;
  localparam logic [2:0] REG_STALL_THR  = 3'd1;
  localparam logic [2:0] REG_MIN_RUN    = 3'd2;
  localparam logic [2:0] REG_MAX_SENSE  = 3'd3;
  localparam logic [2:0] REG_PWM_DUTY   = 3'd4;

  // Register field widths
  localparam int HALF_W = 11;
  localparam int MS_W   = 16;
  localparam int DUTY_W = 8;
  localparam int ADC_W  = 10;

  // Register reset values
  localparam logic [HALF_W-1:0] ZERO_POINT_RST = 11'd1023;
  localparam logic [HALF_W-1:0] STALL_THR_RST  = 11'd33;
  localparam logic [MS_W-1:0]   MIN_RUN_RST    = 16'd500;
  localparam logic [MS_W-1:0]   MAX_SENSE_RST  = 16'd3000;
  localparam logic [DUTY_W-1:0] PWM_DUTY_RST   = 8'd200;

  // Move status codes
  localparam logic STATUS_STALL   = 1'b0;
  localparam logic STATUS_TIMEOUT = 1'b1;

endpackage

### design/gripper_stall_sense_sequencer_unit.sv
// Gripper stall-sense sequencer: motor run, minimum-time wait, windowed current sense.
// The result word for an accepted item is registered and valid in the next cycle.
// Throughput: one item per cycle; the single output register takes a new word whenever
// it is empty or being read in the same cycle.
// Reset (rst, synchronous): sequencer idle, counters and sum cleared, status stall,
// configuration registers back to their defaults, output register empty.
module gripper_stall_sense_sequencer_unit
  import gss_pkg::*;
#(
  parameter int WINDOW   = 200,
  parameter int ADC_BITS = 10
) (
  input  logic              clk,
  input  logic              rst,
  // APB-style configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // request channel
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [1:0]        req_type,
  input  logic              open_request,
  input  logic [ADC_W-1:0]  adc_sample,
  // result channel
  output logic              result_valid,
  input  logic              result_ready,
  output logic              motor_enable,
  output logic              drive_a,
  output logic              drive_b,
  output logic [DUTY_W-1:0] duty_out,
  output logic              busy_res,
  output logic              done_res,
  output logic              status
);

  // Derived widths
  localparam int SMP_W  = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
  localparam int SUM_W  = $clog2(WINDOW * ((1 << SMP_W) - 1) + 1);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int PROD_W = HALF_W + $clog2(WINDOW + 1);
  localparam int CMP_W  = (SUM_W + 1 > PROD_W) ? SUM_W + 1 : PROD_W;
  localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW);
  localparam logic [MS_W-1:0]  MS_MAX  = '1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_MINRUN = 2'd1,
    PH_SENSE  = 2'd2
  } phase_t;

  // Configuration registers, plus zero-point and threshold terms prescaled by WINDOW
  logic [HALF_W-1:0] zero_point_half;
  logic [HALF_W-1:0] stall_threshold_half;
  logic [MS_W-1:0]   min_run_ms;
  logic [MS_W-1:0]   max_sense_ms;
  logic [DUTY_W-1:0] pwm_duty;
  logic [CMP_W-1:0]  zero_scaled;
  logic [CMP_W-1:0]  thr_scaled;

  // Sequencer state
  phase_t            phase, phase_next;
  logic              move_open, move_open_next;
  logic [MS_W-1:0]   elapsed_ms, elapsed_ms_next;
  logic [CNT_W-1:0]  window_count, window_count_next;
  logic [SUM_W-1:0]  window_sum, window_sum_next;
  logic              last_status, last_status_next;
  logic              done_next;

  logic              item_fire;
  logic              cfg_write;
  logic [SMP_W-1:0]  sample;
  logic [SUM_W-1:0]  sum_add;
  logic [CNT_W-1:0]  count_add;
  logic [MS_W-1:0]   elapsed_inc;
  logic [CMP_W-1:0]  twice_sum;
  logic              stalled;
  logic              busy_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign item_ready = !result_valid || result_ready;
  assign item_fire  = item_valid && item_ready;

  // Configuration write; products by WINDOW formed here to keep the item path short
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_point_half      <= ZERO_POINT_RST;
      stall_threshold_half <= STALL_THR_RST;
      min_run_ms           <= MIN_RUN_RST;
      max_sense_ms         <= MAX_SENSE_RST;
      pwm_duty             <= PWM_DUTY_RST;
      zero_scaled          <= CMP_W'(ZERO_POINT_RST) * CMP_W'(WINDOW);
      thr_scaled           <= CMP_W'(STALL_THR_RST) * CMP_W'(WINDOW);
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_ZERO_POINT: begin
          zero_point_half <= pwdata[HALF_W-1:0];
          zero_scaled     <= CMP_W'(pwdata[HALF_W-1:0]) * CMP_W'(WINDOW);
        end
        REG_STALL_THR: begin
          stall_threshold_half <= pwdata[HALF_W-1:0];
          thr_scaled           <= CMP_W'(pwdata[HALF_W-1:0]) * CMP_W'(WINDOW);
        end
        REG_MIN_RUN:   min_run_ms   <= pwdata[MS_W-1:0];
        REG_MAX_SENSE: max_sense_ms <= pwdata[MS_W-1:0];
        REG_PWM_DUTY:  pwm_duty     <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read
  always_comb begin
    unique case (paddr[4:2])
      REG_ZERO_POINT: prdata = 32'(zero_point_half);
      REG_STALL_THR:  prdata = 32'(stall_threshold_half);
      REG_MIN_RUN:    prdata = 32'(min_run_ms);
      REG_MAX_SENSE:  prdata = 32'(max_sense_ms);
      REG_PWM_DUTY:   prdata = 32'(pwm_duty);
      default:        prdata = '0;
    endcase
  end

  // Window arithmetic: |2*sum - zero*WINDOW| >= thr*WINDOW
  assign sample      = adc_sample[SMP_W-1:0];
  assign sum_add     = window_sum + SUM_W'(sample);
  assign count_add   = window_count + CNT_W'(1);
  assign elapsed_inc = (elapsed_ms == MS_MAX) ? elapsed_ms : elapsed_ms + MS_W'(1);
  assign twice_sum   = CMP_W'({sum_add, 1'b0});
  assign stalled     = (twice_sum >= zero_scaled) ?
                       ((twice_sum - zero_scaled) >= thr_scaled) :
                       ((zero_scaled - twice_sum) >= thr_scaled);

  // Next state for one request word
  always_comb begin
    phase_next        = phase;
    move_open_next    = move_open;
    elapsed_ms_next   = elapsed_ms;
    window_count_next = window_count;
    window_sum_next   = window_sum;
    last_status_next  = last_status;
    done_next         = 1'b0;
    case (req_type)
      REQ_START: begin
        if (phase == PH_IDLE) begin
          move_open_next    = open_request;
          elapsed_ms_next   = '0;
          window_count_next = '0;
          window_sum_next   = '0;
          phase_next        = (min_run_ms == '0) ? PH_SENSE : PH_MINRUN;
        end
      end
      REQ_SAMPLE: begin
        if (phase == PH_SENSE) begin
          window_sum_next   = sum_add;
          window_count_next = count_add;
          if (count_add >= WIN_CNT) begin
            window_count_next = '0;
            window_sum_next   = '0;
            if (stalled) begin
              phase_next       = PH_IDLE;
              last_status_next = STATUS_STALL;
              elapsed_ms_next  = '0;
              done_next        = 1'b1;
            end
          end
        end
      end
      REQ_TICK: begin
        if (phase == PH_MINRUN) begin
          elapsed_ms_next = elapsed_inc;
          if (elapsed_inc >= min_run_ms) begin
            phase_next        = PH_SENSE;
            elapsed_ms_next   = '0;
            window_count_next = '0;
            window_sum_next   = '0;
          end
        end else if (phase == PH_SENSE) begin
          elapsed_ms_next = elapsed_inc;
          if (elapsed_inc > max_sense_ms) begin
            phase_next        = PH_IDLE;
            last_status_next  = STATUS_TIMEOUT;
            elapsed_ms_next   = '0;
            window_count_next = '0;
            window_sum_next   = '0;
            done_next         = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign busy_next = (phase_next != PH_IDLE);

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      move_open    <= 1'b0;
      elapsed_ms   <= '0;
      window_count <= '0;
      window_sum   <= '0;
      last_status  <= STATUS_STALL;
      result_valid <= 1'b0;
    end else begin
      if (item_fire) begin
        phase        <= phase_next;
        move_open    <= move_open_next;
        elapsed_ms   <= elapsed_ms_next;
        window_count <= window_count_next;
        window_sum   <= window_sum_next;
        last_status  <= last_status_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted word
  always_ff @(posedge clk) begin
    if (item_fire) begin
      motor_enable <= busy_next;
      drive_a      <= busy_next && !move_open_next;
      drive_b      <= busy_next && move_open_next;
      duty_out     <= busy_next ? pwm_duty : '0;
      busy_res     <= busy_next;
      done_res     <= done_next;
      status       <= last_status_next;
    end
  end

endmodule

### design/gss_checker.sv
// Port-level checks for the gripper stall-sense sequencer, with its bind.
module gss_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic       motor_enable,
  input logic       drive_a,
  input logic       drive_b,
  input logic [7:0] duty_out,
  input logic       busy_res,
  input logic       done_res,
  input logic       status
);

  // A held word keeps its busy, done, status and duty fields until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(busy_res) && $stable(done_res) && $stable(status)
      && $stable(duty_out))
    else $error("result word changed while stalled");

  // Every accepted request produces a word in the next cycle
  a_issue: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> result_valid)
    else $error("accepted request gave no result word");

  // Bridge drive agrees with the busy flag and never shorts
  a_drive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (motor_enable == busy_res) && !(drive_a && drive_b)
      && ((drive_a || drive_b) == busy_res))
    else $error("bridge drive inconsistent with busy");

  // The word that ends a move, and any idle word, shows the motor stopped
  a_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && (done_res || !busy_res) |-> !busy_res && (duty_out == 8'd0))
    else $error("stopped motor still driven");

  // No new word can be taken while a stalled one waits
  a_block: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !item_ready)
    else $error("request accepted over a pending result");

endmodule

bind gripper_stall_sense_sequencer_unit gss_checker u_gss_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .motor_enable (motor_enable),
  .drive_a      (drive_a),
  .drive_b      (drive_b),
  .duty_out     (duty_out),
  .busy_res     (busy_res),
  .done_res     (done_res),
  .status       (status)
);
